// ===== rtl/plo_pkg.sv =====
// Package: shared types and constants for the pin lead-out search block.
`timescale 1ns / 1ps
package plo_pkg;
    localparam int GRID_COLS_DEF    = 64;
    localparam int GRID_ROWS_DEF    = 64;
    localparam int SEARCH_REACH_DEF = 5;
    localparam int NET_BITS_DEF     = 10;
    localparam int COORD_W          = 7;
    localparam int NETF_W           = 10;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 10;
    localparam int IN_W             = 64;
    localparam int OUT_W            = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_NET_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd2;

    localparam logic [1:0] PLANE_HGRID = 2'd0;
    localparam logic [1:0] PLANE_VGRID = 2'd1;
    localparam logic [1:0] PLANE_HMARK = 2'd2;
    localparam logic [1:0] PLANE_VMARK = 2'd3;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_LEAD  = 1'b1;

    // Request passed from the front end to the search engine.
    typedef struct packed {
        logic              action;
        logic [1:0]        plane;
        logic [COORD_W-1:0] wrow;
        logic [COORD_W-1:0] wcol;
        logic [NETF_W-1:0]  wvalue;
        logic [NETF_W-1:0]  net;
        logic [COORD_W-1:0] c0;
        logic [COORD_W-1:0] r0;
        logic [COORD_W-1:0] c1;
        logic [COORD_W-1:0] r1;
    } plo_req_t;

    typedef struct packed {
        logic               kind;
        logic               layer;
        logic [COORD_W-1:0] sc;
        logic [COORD_W-1:0] sr;
        logic [COORD_W-1:0] ec;
        logic [COORD_W-1:0] er;
        logic [NETF_W-1:0]  net;
        logic               any;
        logic               last;
    } plo_res_t;
endpackage

// ===== rtl/pin_lead_out_search.sv =====
// Writes: a write request is stored into its grid as the idle engine takes it from the queue;
// a lead request ends with a final item, after any lead items it produced.
// Flow: one lead request at a time; each walk step is an address state, then a registered grid
// read, up to SEARCH_REACH steps per direction; output stalls hold the engine.
// Results leave through a one-entry output register; a two-entry queue holds requests.
// Reset (aresetn, sync, active low) clears control and presets config; grids are not cleared.
`timescale 1ns / 1ps
module pin_lead_out_search
    import plo_pkg::*;
#(
    parameter int GRID_COLS    = GRID_COLS_DEF,
    parameter int GRID_ROWS    = GRID_ROWS_DEF,
    parameter int SEARCH_REACH = SEARCH_REACH_DEF,
    parameter int NET_BITS     = NET_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,    // action
    // write_plane, write_row, write_col, write_value, net_id,
    // first_col, first_row, second_col, second_row
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_tuser,    // item_kind
    // lead_layer, start_col, start_row, end_col, end_row, lead_net, any_lead
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    logic [NETF_W-1:0]  net_count_reg;
    logic [COORD_W-1:0] column_count_reg, row_count_reg;
    logic q_valid, q_ready;
    plo_req_t q_req;
    plo_res_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            net_count_reg    <= '0;
            column_count_reg <= 7'd64;
            row_count_reg    <= 7'd64;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NET_COUNT: net_count_reg <= cfg_data;
                CFG_COL_COUNT: column_count_reg <= cfg_data[COORD_W-1:0];
                CFG_ROW_COUNT: row_count_reg <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    plo_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_user(s_tuser), .in_data(s_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    plo_engine #(
        .GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS),
        .SEARCH_REACH(SEARCH_REACH), .NET_BITS(NET_BITS)
    ) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .net_count(net_count_reg), .column_count(column_count_reg),
        .row_count(row_count_reg),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {res.any, res.net, res.er, res.ec, res.sr, res.sc, res.layer};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

`ifndef NO_ASSERTIONS
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == m_tuser)) else $error("last flag differs from kind");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                     $stable(m_tlast)))
        else $error("result changed while stalled");
    a_lead_net: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[38:0] == 39'd0))
        else $error("final item carries lead data");
`endif
endmodule

// ===== rtl/plo_front.sv =====
// Front end: input request capture and a two-entry queue toward the search engine.
`timescale 1ns / 1ps
module plo_front
    import plo_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_user,
    input  logic [IN_W-1:0] in_data,
    output logic            q_valid,
    input  logic            q_ready,
    output plo_req_t        q_req
);
    plo_req_t  ent_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    plo_req_t  d;
    logic      push, pop;

    always_comb begin
        d.action = in_user;
        d.plane  = in_data[1:0];
        d.wrow   = in_data[8:2];
        d.wcol   = in_data[15:9];
        d.wvalue = in_data[25:16];
        d.net    = in_data[35:26];
        d.c0     = in_data[42:36];
        d.r0     = in_data[49:43];
        d.c1     = in_data[56:50];
        d.r1     = in_data[63:57];
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = ent_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= d;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== rtl/plo_engine.sv =====
// Search engine: grid memories, directional walks and result generation.
`timescale 1ns / 1ps
module plo_engine
    import plo_pkg::*;
#(
    parameter int GRID_COLS    = GRID_COLS_DEF,
    parameter int GRID_ROWS    = GRID_ROWS_DEF,
    parameter int SEARCH_REACH = SEARCH_REACH_DEF,
    parameter int NET_BITS     = NET_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  plo_req_t          q_req,
    input  logic [NETF_W-1:0] net_count,
    input  logic [COORD_W-1:0] column_count,
    input  logic [COORD_W-1:0] row_count,
    output logic              res_valid,
    input  logic              res_ready,
    output plo_res_t          res
);
    localparam int CB = $clog2(GRID_COLS);
    localparam int RB = $clog2(GRID_ROWS);
    localparam int AW = CB + RB;
    localparam int DEPTH = 1 << AW;
    localparam int DW = $clog2(SEARCH_REACH + 1);
    localparam int PW = 12;   // unsigned coordinate width covers the full parameter range

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_PIN   = 8'b00000010,
        S_PINRD = 8'b00000100,
        S_WALK  = 8'b00001000,
        S_WRD   = 8'b00010000,
        S_PICK  = 8'b00100000,
        S_EMIT  = 8'b01000000,
        S_FIN   = 8'b10000000
    } st_t;

    logic [NET_BITS-1:0] hg_mem [DEPTH];
    logic [NET_BITS-1:0] vg_mem [DEPTH];
    logic [NET_BITS-1:0] hm_mem [DEPTH];
    logic [NET_BITS-1:0] vm_mem [DEPTH];
    logic [NET_BITS-1:0] hg_q, vg_q, hm_q, vm_q;

    st_t st_reg;
    plo_req_t req_reg;
    logic pin_reg, layer_reg, any_reg;
    logic [1:0] dir_reg;
    logic [DW-1:0] k_reg;
    logic [DW:0] dist_reg [4];
    logic [AW-1:0] raddr;
    logic rd_inb_reg;
    plo_res_t out_reg;
    logic out_v_reg;

    logic [PW-1:0] pr, pc, tr, tc, cmax, rmax;
    logic inb;
    logic [NETF_W-1:0] pv, ov, pmv, omv, nc;
    logic [PW-1:0] lim;
    logic [DW:0] fail;

    assign nc   = net_count;
    assign fail = (DW+1)'(SEARCH_REACH + 1);
    assign cmax = (PW'(column_count) > PW'(GRID_COLS)) ? PW'(GRID_COLS) : PW'(column_count);
    assign rmax = (PW'(row_count) > PW'(GRID_ROWS)) ? PW'(GRID_ROWS) : PW'(row_count);
    assign pc = pin_reg ? PW'(req_reg.c1) : PW'(req_reg.c0);
    assign pr = pin_reg ? PW'(req_reg.r1) : PW'(req_reg.r0);

    // cell currently addressed: the pin, or in S_WALK the walk cell
    always_comb begin
        tr = pr;
        tc = pc;
        if (st_reg == S_WALK) begin
            unique case (dir_reg)
                2'd0: tc = pc + PW'(k_reg);
                2'd1: tc = pc - PW'(k_reg);
                2'd2: tr = pr + PW'(k_reg);
                default: tr = pr - PW'(k_reg);
            endcase
        end
        inb = (tr >= PW'(1)) && (tr <= PW'(GRID_ROWS)) &&
              (tc >= PW'(1)) && (tc <= PW'(GRID_COLS));
        raddr = {RB'(tr - PW'(1)), CB'(tc - PW'(1))};
    end

    // step limit for the current direction
    always_comb begin
        unique case (dir_reg)
            2'd0: lim = (cmax > pc) ? cmax - pc : '0;
            2'd1: lim = pc - PW'(1);
            2'd2: lim = (rmax > pr) ? rmax - pr : '0;
            default: lim = pr - PW'(1);
        endcase
        if (lim > PW'(SEARCH_REACH)) lim = PW'(SEARCH_REACH);
    end

    logic wr_en;
    logic [AW-1:0] waddr;
    assign wr_en = (st_reg == S_IDLE) && q_valid && (q_req.action == ACT_WRITE) &&
                   (q_req.wrow >= 7'd1) && (PW'(q_req.wrow) <= PW'(GRID_ROWS)) &&
                   (q_req.wcol >= 7'd1) && (PW'(q_req.wcol) <= PW'(GRID_COLS));
    assign waddr = {RB'(PW'(q_req.wrow) - PW'(1)), CB'(PW'(q_req.wcol) - PW'(1))};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            case (q_req.plane)
                PLANE_HGRID: hg_mem[waddr] <= NET_BITS'(q_req.wvalue);
                PLANE_VGRID: vg_mem[waddr] <= NET_BITS'(q_req.wvalue);
                PLANE_HMARK: hm_mem[waddr] <= NET_BITS'(q_req.wvalue);
                default:     vm_mem[waddr] <= NET_BITS'(q_req.wvalue);
            endcase
        end
        hg_q <= hg_mem[raddr];
        vg_q <= vg_mem[raddr];
        hm_q <= hm_mem[raddr];
        vm_q <= vm_mem[raddr];
        rd_inb_reg <= inb;
    end

    logic [NETF_W-1:0] hgv, vgv, hmv, vmv;
    assign hgv = rd_inb_reg ? NETF_W'(hg_q) : '0;
    assign vgv = rd_inb_reg ? NETF_W'(vg_q) : '0;
    assign hmv = rd_inb_reg ? NETF_W'(hm_q) : '0;
    assign vmv = rd_inb_reg ? NETF_W'(vm_q) : '0;
    assign pv  = layer_reg ? vgv : hgv;
    assign ov  = layer_reg ? hgv : vgv;
    assign pmv = layer_reg ? vmv : hmv;
    assign omv = layer_reg ? hmv : vmv;

    assign q_ready   = (st_reg == S_IDLE) && (q_req.action == ACT_WRITE || !out_v_reg);
    assign res_valid = out_v_reg;
    assign res       = out_reg;

    logic hwin, vwin, rsel, dsel;
    logic [DW:0] hx, vy;
    assign rsel = dist_reg[0] < dist_reg[1];
    assign dsel = dist_reg[2] < dist_reg[3];
    assign hx = rsel ? dist_reg[0] : dist_reg[1];
    assign vy = dsel ? dist_reg[2] : dist_reg[3];
    assign hwin = (hx < vy) && (hx < (DW+1)'(SEARCH_REACH));
    assign vwin = vy < (DW+1)'(SEARCH_REACH);

    logic out_free, ld_out;
    plo_res_t lead_res, fin_res;
    assign out_free = !out_v_reg || res_ready;
    assign ld_out   = ((st_reg == S_EMIT) || (st_reg == S_FIN)) && out_free;

    always_comb begin
        lead_res = '0;
        lead_res.layer = layer_reg;
        lead_res.net = req_reg.net;
        if (hwin) begin
            lead_res.sr = COORD_W'(pr);
            lead_res.er = COORD_W'(pr);
            lead_res.sc = rsel ? COORD_W'(pc + PW'(1)) : COORD_W'(pc - PW'(hx));
            lead_res.ec = rsel ? COORD_W'(pc + PW'(hx)) : COORD_W'(pc - PW'(1));
        end else begin
            lead_res.sc = COORD_W'(pc);
            lead_res.ec = COORD_W'(pc);
            lead_res.sr = dsel ? COORD_W'(pr + PW'(1)) : COORD_W'(pr - PW'(vy));
            lead_res.er = dsel ? COORD_W'(pr + PW'(vy)) : COORD_W'(pr - PW'(1));
        end
        fin_res = '0;
        fin_res.kind = 1'b1;
        fin_res.any = any_reg;
        fin_res.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            out_v_reg <= 1'b0;
        end else begin
            out_v_reg <= ld_out || (out_v_reg && !res_ready);
            unique case (st_reg)
                S_IDLE: begin
                    if (q_valid && q_ready && q_req.action == ACT_LEAD) begin
                        req_reg <= q_req;
                        pin_reg <= 1'b0;
                        any_reg <= 1'b0;
                        st_reg  <= S_PIN;
                    end
                end
                S_PIN: st_reg <= S_PINRD;
                S_PINRD: begin
                    dir_reg <= 2'd0;
                    k_reg   <= DW'(1);
                    if (hgv > nc) begin
                        layer_reg <= 1'b1;
                        st_reg <= S_WALK;
                    end else if (vgv > nc) begin
                        layer_reg <= 1'b0;
                        st_reg <= S_WALK;
                    end else begin
                        st_reg <= pin_reg ? S_FIN : S_PIN;
                        pin_reg <= 1'b1;
                    end
                    for (int i = 0; i < 4; i++) dist_reg[i] <= fail;
                end
                S_WALK: begin
                    if (PW'(k_reg) > lim) begin
                        // direction exhausted
                        k_reg <= DW'(1);
                        dir_reg <= dir_reg + 2'd1;
                        st_reg <= (dir_reg == 2'd3) ? S_PICK : S_WALK;
                    end else begin
                        st_reg <= S_WRD;
                    end
                end
                S_WRD: begin
                    logic stop;
                    stop = 1'b1;
                    if (pv == req_reg.net || pv > nc || pmv != '0) begin
                        stop = 1'b1;
                    end else if (ov <= nc && omv == '0) begin
                        dist_reg[dir_reg] <= {1'b0, k_reg};
                    end else begin
                        stop = 1'b0;
                    end
                    if (stop || k_reg == DW'(SEARCH_REACH)) begin
                        k_reg <= DW'(1);
                        dir_reg <= dir_reg + 2'd1;
                        st_reg <= (dir_reg == 2'd3) ? S_PICK : S_WALK;
                    end else begin
                        k_reg <= k_reg + DW'(1);
                        st_reg <= S_WALK;
                    end
                end
                S_PICK: begin
                    if (hwin || vwin) begin
                        // hold while the previous result still waits
                        if (out_free) begin
                            out_reg <= lead_res;
                            st_reg <= S_EMIT;
                        end
                    end else begin
                        st_reg <= pin_reg ? S_FIN : S_PIN;
                        pin_reg <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        any_reg <= 1'b1;
                        st_reg <= pin_reg ? S_FIN : S_PIN;
                        pin_reg <= 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        out_reg <= fin_res;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
